### sv/arrowhead_vertex_generator_macros.svh
// Assertion macros for the arrowhead vertex generator.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef ARROWHEAD_VERTEX_GENERATOR_MACROS_SVH
`define ARROWHEAD_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication
`define AVG_CHK_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define AVG_CHK_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### sv/avg_pkg.sv
// Shared types and constants for the arrowhead vertex generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package avg_pkg;

    localparam int SIZE_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef logic [SIZE_W-1:0] t_size;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SIZE = 2'd0,
        CFG_END_ON   = 2'd1,
        CFG_START_ON = 2'd2
    } t_cfg_idx;

    // pipeline advance and stage-entry valid
    typedef struct packed {
        logic ce;
        logic vld;
    } t_flow;

endpackage

`default_nettype wire

### sv/avg_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on avg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avg_sqrt #(
    parameter int RAD_W  = 49,
    parameter int SIDE_W = 146
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  avg_pkg::t_flow            i_flow,
    input  logic [RAD_W-1:0]          i_rad,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_vld,
    output logic [(RAD_W+1)/2-1:0]    o_root,
    output logic [SIDE_W-1:0]         o_side
);
    import avg_pkg::*;

    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int PAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    logic              r_vld  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [PAD_W-1:0]  r_rad  [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    logic              s_vld  [ROOT_W];
    logic [REM_W-1:0]  s_rem  [ROOT_W];
    logic [ROOT_W-1:0] s_root [ROOT_W];
    logic [PAD_W-1:0]  s_rad  [ROOT_W];
    logic [SIDE_W-1:0] s_side [ROOT_W];
    logic [REM_W-1:0]  s_cur  [ROOT_W];
    logic [REM_W-1:0]  s_try  [ROOT_W];

    logic [REM_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];

    always_comb begin
        s_vld[0]  = i_flow.vld;
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_rad[0]  = PAD_W'(i_rad);
        s_side[0] = i_side;
        for (int j = 1; j < ROOT_W; j++) begin
            s_vld[j]  = r_vld[j-1];
            s_rem[j]  = r_rem[j-1];
            s_root[j] = r_root[j-1];
            s_rad[j]  = r_rad[j-1];
            s_side[j] = r_side[j-1];
        end
    end

    always_comb begin
        for (int j = 0; j < ROOT_W; j++) begin
            s_cur[j] = {s_rem[j][REM_W-3:0], s_rad[j][PAD_W-1 -: 2]};
            s_try[j] = {{(REM_W-ROOT_W-2){1'b0}}, s_root[j], 2'b01};
            if (s_cur[j] >= s_try[j]) begin
                n_rem[j]  = s_cur[j] - s_try[j];
                n_root[j] = {s_root[j][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[j]  = s_cur[j];
                n_root[j] = {s_root[j][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ROOT_W; j++) r_vld[j] <= 1'b0;
        end else if (i_flow.ce) begin
            for (int j = 0; j < ROOT_W; j++) r_vld[j] <= s_vld[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.ce) begin
            for (int j = 0; j < ROOT_W; j++) begin
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
                r_rad[j]  <= {s_rad[j][PAD_W-3:0], 2'b00};
                r_side[j] <= s_side[j];
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

`default_nettype wire

### sv/avg_div.sv
// Pipelined restoring divider, two numerators over a shared divisor.
// One quotient bit per stage. Depends on avg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avg_div #(
    parameter int NUM_W  = 41,
    parameter int DEN_W  = 25,
    parameter int Q_W    = 17,
    parameter int SIDE_W = 110
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  avg_pkg::t_flow     i_flow,
    input  logic [DEN_W-1:0]   i_den,
    input  logic [NUM_W-1:0]   i_num_x,
    input  logic [NUM_W-1:0]   i_num_y,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_vld,
    output logic [Q_W-1:0]     o_q_x,
    output logic [Q_W-1:0]     o_q_y,
    output logic [SIDE_W-1:0]  o_side
);
    import avg_pkg::*;

    logic              r_vld  [Q_W];
    logic [DEN_W-1:0]  r_den  [Q_W];
    logic [DEN_W-1:0]  r_rx   [Q_W];
    logic [DEN_W-1:0]  r_ry   [Q_W];
    logic [Q_W-1:0]    r_bx   [Q_W];
    logic [Q_W-1:0]    r_by   [Q_W];
    logic [Q_W-1:0]    r_qx   [Q_W];
    logic [Q_W-1:0]    r_qy   [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];

    logic              s_vld  [Q_W];
    logic [DEN_W-1:0]  s_den  [Q_W];
    logic [DEN_W-1:0]  s_rx   [Q_W];
    logic [DEN_W-1:0]  s_ry   [Q_W];
    logic [Q_W-1:0]    s_bx   [Q_W];
    logic [Q_W-1:0]    s_by   [Q_W];
    logic [Q_W-1:0]    s_qx   [Q_W];
    logic [Q_W-1:0]    s_qy   [Q_W];
    logic [SIDE_W-1:0] s_side [Q_W];
    logic [DEN_W:0]    s_cx   [Q_W];
    logic [DEN_W:0]    s_cy   [Q_W];

    logic [DEN_W-1:0]  n_rx   [Q_W];
    logic [DEN_W-1:0]  n_ry   [Q_W];
    logic [Q_W-1:0]    n_qx   [Q_W];
    logic [Q_W-1:0]    n_qy   [Q_W];

    always_comb begin
        s_vld[0]  = i_flow.vld;
        s_den[0]  = i_den;
        s_rx[0]   = DEN_W'(i_num_x >> Q_W);
        s_ry[0]   = DEN_W'(i_num_y >> Q_W);
        s_bx[0]   = i_num_x[Q_W-1:0];
        s_by[0]   = i_num_y[Q_W-1:0];
        s_qx[0]   = '0;
        s_qy[0]   = '0;
        s_side[0] = i_side;
        for (int j = 1; j < Q_W; j++) begin
            s_vld[j]  = r_vld[j-1];
            s_den[j]  = r_den[j-1];
            s_rx[j]   = r_rx[j-1];
            s_ry[j]   = r_ry[j-1];
            s_bx[j]   = r_bx[j-1];
            s_by[j]   = r_by[j-1];
            s_qx[j]   = r_qx[j-1];
            s_qy[j]   = r_qy[j-1];
            s_side[j] = r_side[j-1];
        end
    end

    always_comb begin
        for (int j = 0; j < Q_W; j++) begin
            s_cx[j] = {s_rx[j], s_bx[j][Q_W-1]};
            s_cy[j] = {s_ry[j], s_by[j][Q_W-1]};
            if (s_cx[j] >= {1'b0, s_den[j]}) begin
                n_rx[j] = DEN_W'(s_cx[j] - {1'b0, s_den[j]});
                n_qx[j] = {s_qx[j][Q_W-2:0], 1'b1};
            end else begin
                n_rx[j] = DEN_W'(s_cx[j]);
                n_qx[j] = {s_qx[j][Q_W-2:0], 1'b0};
            end
            if (s_cy[j] >= {1'b0, s_den[j]}) begin
                n_ry[j] = DEN_W'(s_cy[j] - {1'b0, s_den[j]});
                n_qy[j] = {s_qy[j][Q_W-2:0], 1'b1};
            end else begin
                n_ry[j] = DEN_W'(s_cy[j]);
                n_qy[j] = {s_qy[j][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < Q_W; j++) r_vld[j] <= 1'b0;
        end else if (i_flow.ce) begin
            for (int j = 0; j < Q_W; j++) r_vld[j] <= s_vld[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.ce) begin
            for (int j = 0; j < Q_W; j++) begin
                r_den[j]  <= s_den[j];
                r_rx[j]   <= n_rx[j];
                r_ry[j]   <= n_ry[j];
                r_bx[j]   <= {s_bx[j][Q_W-2:0], 1'b0};
                r_by[j]   <= {s_by[j][Q_W-2:0], 1'b0};
                r_qx[j]   <= n_qx[j];
                r_qy[j]   <= n_qy[j];
                r_side[j] <= s_side[j];
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_q_x  = r_qx[Q_W-1];
    assign o_q_y  = r_qy[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

`default_nettype wire

### sv/avg_out.sv
// Output register with skid stage; produces the pipeline advance enable.
// Depends on avg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avg_out #(
    parameter int W = 194
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [W-1:0]  i_data,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [W-1:0]  o_data,
    output logic          o_ce
);
    import avg_pkg::*;

    logic         r_out_vld;
    logic         r_skid_vld;
    logic [W-1:0] r_out;
    logic [W-1:0] r_skid;
    logic         w_take;

    assign w_take = i_vld && !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_take;
            end
        end else if (w_take) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (w_take) begin
                r_out <= i_data;
            end
        end else if (w_take) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;
    assign o_ce    = !r_skid_vld;

endmodule

`default_nettype wire

### sv/arrowhead_vertex_generator.sv
// Throughput: one segment word per cycle while o_in_ready is high; the root and divide
// pipelines retire one bit per stage, so their depth sets the latency.
// Reset: synchronous, clears all valid bits and loads register defaults; no clearing pass.
// Depends on avg_pkg, avg_sqrt, avg_div, avg_out and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "arrowhead_vertex_generator_macros.svh"

module arrowhead_vertex_generator #(
    parameter int FRAC_BITS     = 8,
    parameter int COORD_BITS    = 24,
    parameter int ROTATE_STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [avg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [avg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COORD_BITS-1:0]        i_start_x,
    input  logic signed [COORD_BITS-1:0]        i_start_y,
    input  logic signed [COORD_BITS-1:0]        i_end_x,
    input  logic signed [COORD_BITS-1:0]        i_end_y,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_end_valid,
    output logic signed [COORD_BITS-1:0]        o_end_left_x,
    output logic signed [COORD_BITS-1:0]        o_end_left_y,
    output logic signed [COORD_BITS-1:0]        o_end_right_x,
    output logic signed [COORD_BITS-1:0]        o_end_right_y,
    output logic                                o_start_valid,
    output logic signed [COORD_BITS-1:0]        o_start_left_x,
    output logic signed [COORD_BITS-1:0]        o_start_left_y,
    output logic signed [COORD_BITS-1:0]        o_start_right_x,
    output logic signed [COORD_BITS-1:0]        o_start_right_y
);
    import avg_pkg::*;

    function automatic longint unsigned f_isqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bv;
        longint unsigned rem;
        rem = v;
        res = 0;
        bv  = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bv > rem) bv = bv >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bv != 0) begin
                if (rem >= res + bv) begin
                    rem = rem - (res + bv);
                    res = (res >> 1) + bv;
                end else begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
        end
        return res;
    endfunction

    localparam int CW     = COORD_BITS;
    localparam int K      = ROTATE_STAGES;
    localparam int DIFF_W = CW + 1;
    localparam int MAG_W  = CW;
    localparam int SQ_W   = 2 * CW;
    localparam int RAD_W  = 2 * CW + 1;
    localparam int LEN_W  = (RAD_W + 1) / 2;
    localparam int NUM_W  = CW + K + 1;
    localparam int Q_W    = K + 1;
    localparam int UX_W   = K + 2;
    localparam int PC_W   = 2 * K + 3;
    localparam int RM_W   = PC_W - 1;
    localparam int PR_W   = RM_W + SIZE_W;
    localparam int SH     = 2 * K - FRAC_BITS;
    localparam int OFF_W  = PR_W + 1 - SH;
    localparam int SUM_W  = ((CW > OFF_W) ? CW : OFF_W) + 2;

    localparam longint unsigned C30_L = (f_isqrt(64'd3 << (2 * K)) + 64'd1) >> 1;
    localparam logic signed [PC_W-1:0] C30_S = PC_W'(C30_L);
    localparam logic [PR_W:0] HALF =
        (SH > 0) ? ((PR_W+1)'(1) << ((SH > 0) ? SH - 1 : 0)) : '0;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        $signed({{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } t_pts;

    typedef struct packed {
        t_pts             p;
        logic             sgnx;
        logic             sgny;
        logic [MAG_W-1:0] magx;
        logic [MAG_W-1:0] magy;
    } t_sq_side;

    typedef struct packed {
        t_pts  p;
        logic  sgnx;
        logic  sgny;
        t_size size;
    } t_dv_side;

    typedef struct packed {
        logic          end_valid;
        logic [CW-1:0] elx;
        logic [CW-1:0] ely;
        logic [CW-1:0] erx;
        logic [CW-1:0] ery;
        logic          start_valid;
        logic [CW-1:0] slx;
        logic [CW-1:0] sly;
        logic [CW-1:0] srx;
        logic [CW-1:0] sry;
    } t_res;

    logic w_ce;

    // configuration
    t_size r_max;
    logic  r_end_on;
    logic  r_start_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= t_size'(20);
            r_end_on   <= 1'b1;
            r_start_on <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_SIZE: r_max      <= i_cfg_data[SIZE_W-1:0];
                CFG_END_ON:   r_end_on   <= i_cfg_data[0];
                CFG_START_ON: r_start_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stages A..D: differences, magnitudes, squares, sum
    logic                     r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    t_pts                     r_a_p, r_b_p, r_c_p, r_d_p;
    logic signed [DIFF_W-1:0] r_a_dx, r_a_dy;
    logic                     r_b_sgnx, r_b_sgny, r_c_sgnx, r_c_sgny, r_d_sgnx, r_d_sgny;
    logic [MAG_W-1:0]         r_b_magx, r_b_magy, r_c_magx, r_c_magy, r_d_magx, r_d_magy;
    logic [SQ_W-1:0]          r_c_sqx, r_c_sqy;
    logic [RAD_W-1:0]         r_d_rad;
    logic signed [DIFF_W-1:0] n_b_ax, n_b_ay;

    assign n_b_ax = r_a_dx[DIFF_W-1] ? -r_a_dx : r_a_dx;
    assign n_b_ay = r_a_dy[DIFF_W-1] ? -r_a_dy : r_a_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (w_ce) begin
            r_a_vld <= i_in_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_p    <= '{sx: i_start_x, sy: i_start_y, ex: i_end_x, ey: i_end_y};
            r_a_dx   <= DIFF_W'(i_end_x) - DIFF_W'(i_start_x);
            r_a_dy   <= DIFF_W'(i_end_y) - DIFF_W'(i_start_y);
            r_b_p    <= r_a_p;
            r_b_sgnx <= r_a_dx[DIFF_W-1];
            r_b_sgny <= r_a_dy[DIFF_W-1];
            r_b_magx <= n_b_ax[MAG_W-1:0];
            r_b_magy <= n_b_ay[MAG_W-1:0];
            r_c_p    <= r_b_p;
            r_c_sgnx <= r_b_sgnx;
            r_c_sgny <= r_b_sgny;
            r_c_magx <= r_b_magx;
            r_c_magy <= r_b_magy;
            r_c_sqx  <= SQ_W'(r_b_magx) * SQ_W'(r_b_magx);
            r_c_sqy  <= SQ_W'(r_b_magy) * SQ_W'(r_b_magy);
            r_d_p    <= r_c_p;
            r_d_sgnx <= r_c_sgnx;
            r_d_sgny <= r_c_sgny;
            r_d_magx <= r_c_magx;
            r_d_magy <= r_c_magy;
            r_d_rad  <= RAD_W'(r_c_sqx) + RAD_W'(r_c_sqy);
        end
    end

    // segment length
    logic       w_sq_vld;
    logic [LEN_W-1:0] w_len;
    t_sq_side   w_sq_side;
    t_sq_side   w_sq_in;

    assign w_sq_in = '{p: r_d_p, sgnx: r_d_sgnx, sgny: r_d_sgny,
                       magx: r_d_magx, magy: r_d_magy};

    avg_sqrt #(
        .RAD_W  (RAD_W),
        .SIDE_W ($bits(t_sq_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{ce: w_ce, vld: r_d_vld}),
        .i_rad   (r_d_rad),
        .i_side  (w_sq_in),
        .o_vld   (w_sq_vld),
        .o_root  (w_len),
        .o_side  (w_sq_side)
    );

    // stage P: rounded numerators and head size
    logic             r_p_vld;
    logic [LEN_W-1:0] r_p_len;
    logic [NUM_W-1:0] r_p_nx, r_p_ny;
    t_dv_side         r_p_side;
    logic [LEN_W-1:0] w_lsz;
    t_size            n_p_size;

    assign w_lsz = w_len >> (FRAC_BITS + 1);

    always_comb begin
        if (w_lsz > LEN_W'(r_max)) begin
            n_p_size = r_max;
        end else begin
            n_p_size = SIZE_W'(w_lsz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_ce) begin
            r_p_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_p_len  <= w_len;
            r_p_nx   <= NUM_W'({w_sq_side.magx, {K{1'b0}}}) + NUM_W'(w_len >> 1);
            r_p_ny   <= NUM_W'({w_sq_side.magy, {K{1'b0}}}) + NUM_W'(w_len >> 1);
            r_p_side <= '{p: w_sq_side.p, sgnx: w_sq_side.sgnx, sgny: w_sq_side.sgny,
                          size: n_p_size};
        end
    end

    // unit direction
    logic       w_dv_vld;
    logic [Q_W-1:0] w_qx, w_qy;
    t_dv_side   w_dv_side;

    avg_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (LEN_W),
        .Q_W    (Q_W),
        .SIDE_W ($bits(t_dv_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{ce: w_ce, vld: r_p_vld}),
        .i_den   (r_p_len),
        .i_num_x (r_p_nx),
        .i_num_y (r_p_ny),
        .i_side  (r_p_side),
        .o_vld   (w_dv_vld),
        .o_q_x   (w_qx),
        .o_q_y   (w_qy),
        .o_side  (w_dv_side)
    );

    // rotation and scaling
    logic                   r_r1_vld, r_r2_vld, r_r3_vld, r_m1_vld, r_m2_vld, r_m3_vld, r_m4_vld;
    t_pts                   r_r1_p, r_r2_p, r_r3_p, r_m1_p, r_m2_p, r_m3_p;
    t_size                  r_r1_size, r_r2_size, r_r3_size, r_m1_size;
    logic signed [UX_W-1:0] r_r1_ux, r_r1_uy;
    logic signed [PC_W-1:0] r_r2_pcx, r_r2_pcy, r_r2_hx, r_r2_hy;
    logic signed [PC_W-1:0] r_r3_rot [4];
    logic [RM_W-1:0]        r_m1_mag [4];
    logic [3:0]             r_m1_neg, r_m2_neg, r_m3_neg;
    logic [PR_W-1:0]        r_m2_prod [4];
    logic [OFF_W-1:0]       r_m3_off [4];
    logic signed [SUM_W-1:0] r_m4_sum [8];

    logic signed [UX_W-1:0] w_uqx, w_uqy;
    logic signed [PC_W-1:0] w_r1x, w_r1y;
    logic signed [SUM_W-1:0] w_be [4];
    logic signed [SUM_W-1:0] w_bs [4];
    logic signed [SUM_W-1:0] w_om [4];
    logic signed [SUM_W-1:0] n_m4_sum [8];
    logic signed [PC_W-1:0] w_rneg [4];

    assign w_uqx = $signed({1'b0, w_qx});
    assign w_uqy = $signed({1'b0, w_qy});
    assign w_r1x = PC_W'(r_r1_ux);
    assign w_r1y = PC_W'(r_r1_uy);

    always_comb begin
        w_be[0] = SUM_W'(r_m3_p.ex);
        w_be[1] = SUM_W'(r_m3_p.ey);
        w_be[2] = SUM_W'(r_m3_p.ex);
        w_be[3] = SUM_W'(r_m3_p.ey);
        w_bs[0] = SUM_W'(r_m3_p.sx);
        w_bs[1] = SUM_W'(r_m3_p.sy);
        w_bs[2] = SUM_W'(r_m3_p.sx);
        w_bs[3] = SUM_W'(r_m3_p.sy);
        for (int k = 0; k < 4; k++) begin
            w_om[k]       = $signed(SUM_W'(r_m3_off[k]));
            n_m4_sum[k]   = r_m3_neg[k] ? w_be[k] + w_om[k] : w_be[k] - w_om[k];
            n_m4_sum[k+4] = r_m3_neg[k] ? w_bs[k] - w_om[k] : w_bs[k] + w_om[k];
            w_rneg[k]     = -r_r3_rot[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_vld <= 1'b0;
            r_r2_vld <= 1'b0;
            r_r3_vld <= 1'b0;
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
            r_m4_vld <= 1'b0;
        end else if (w_ce) begin
            r_r1_vld <= w_dv_vld;
            r_r2_vld <= r_r1_vld;
            r_r3_vld <= r_r2_vld;
            r_m1_vld <= r_r3_vld;
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
            r_m4_vld <= r_m3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_r1_p    <= w_dv_side.p;
            r_r1_size <= w_dv_side.size;
            r_r1_ux   <= w_dv_side.sgnx ? -w_uqx : w_uqx;
            r_r1_uy   <= w_dv_side.sgny ? -w_uqy : w_uqy;

            r_r2_p    <= r_r1_p;
            r_r2_size <= r_r1_size;
            r_r2_pcx  <= w_r1x * C30_S;
            r_r2_pcy  <= w_r1y * C30_S;
            r_r2_hx   <= w_r1x <<< (K - 1);
            r_r2_hy   <= w_r1y <<< (K - 1);

            r_r3_p      <= r_r2_p;
            r_r3_size   <= r_r2_size;
            r_r3_rot[0] <= r_r2_pcx + r_r2_hy;
            r_r3_rot[1] <= r_r2_pcy - r_r2_hx;
            r_r3_rot[2] <= r_r2_pcx - r_r2_hy;
            r_r3_rot[3] <= r_r2_pcy + r_r2_hx;

            r_m1_p    <= r_r3_p;
            r_m1_size <= r_r3_size;
            r_m2_p    <= r_m1_p;
            r_m2_neg  <= r_m1_neg;
            r_m3_p    <= r_m2_p;
            r_m3_neg  <= r_m2_neg;
            for (int k = 0; k < 4; k++) begin
                r_m1_neg[k]  <= r_r3_rot[k][PC_W-1];
                r_m1_mag[k]  <= r_r3_rot[k][PC_W-1] ? RM_W'(w_rneg[k]) : RM_W'(r_r3_rot[k]);
                r_m2_prod[k] <= PR_W'(r_m1_mag[k]) * PR_W'(r_m1_size);
                r_m3_off[k]  <= OFF_W'(((PR_W+1)'(r_m2_prod[k]) + HALF) >> SH);
            end
            for (int k = 0; k < 8; k++) begin
                r_m4_sum[k] <= n_m4_sum[k];
            end
        end
    end

    // saturate and gate
    logic [CW-1:0] w_sat [8];
    t_res          w_res;
    t_res          w_out;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (r_m4_sum[k] > SAT_HI) begin
                w_sat[k] = SAT_HI[CW-1:0];
            end else if (r_m4_sum[k] < SAT_LO) begin
                w_sat[k] = SAT_LO[CW-1:0];
            end else begin
                w_sat[k] = r_m4_sum[k][CW-1:0];
            end
        end
        w_res.end_valid   = r_end_on;
        w_res.elx         = r_end_on ? w_sat[0] : '0;
        w_res.ely         = r_end_on ? w_sat[1] : '0;
        w_res.erx         = r_end_on ? w_sat[2] : '0;
        w_res.ery         = r_end_on ? w_sat[3] : '0;
        w_res.start_valid = r_start_on;
        w_res.slx         = r_start_on ? w_sat[4] : '0;
        w_res.sly         = r_start_on ? w_sat[5] : '0;
        w_res.srx         = r_start_on ? w_sat[6] : '0;
        w_res.sry         = r_start_on ? w_sat[7] : '0;
    end

    avg_out #(
        .W ($bits(t_res))
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_m4_vld),
        .i_data  (w_res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (w_out),
        .o_ce    (w_ce)
    );

    assign o_in_ready      = w_ce;
    assign o_end_valid     = w_out.end_valid;
    assign o_end_left_x    = w_out.elx;
    assign o_end_left_y    = w_out.ely;
    assign o_end_right_x   = w_out.erx;
    assign o_end_right_y   = w_out.ery;
    assign o_start_valid   = w_out.start_valid;
    assign o_start_left_x  = w_out.slx;
    assign o_start_left_y  = w_out.sly;
    assign o_start_right_x = w_out.srx;
    assign o_start_right_y = w_out.sry;

    `AVG_CHK_NOW(a_skid_needs_out, !w_ce, o_out_valid, "skid full while output empty")
    `AVG_CHK_NEXT(a_stall_holds_last, !w_ce && r_m4_vld, r_m4_vld, "stalled word lost")
    `AVG_CHK_NOW(a_end_off_zero, o_out_valid && !o_end_valid,
        o_end_left_x == '0 && o_end_right_y == '0, "disabled end head not zero")

endmodule

`default_nettype wire
